// ----- sv/grlr_pkg.sv -----
`default_nettype none

package grlr_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = 13;
  localparam int PROD_W      = VAL_W + CNT_W;

  // Quotient bits produced by each pass of the shared divider
  localparam int DIV1_STEPS  = IDX_W;
  localparam int DIV2_STEPS  = VAL_W;
  localparam int STEP_W      = $clog2(DIV2_STEPS);

  // Request function codes
  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SOURCE_COUNT = 1'b0,
    REG_DEST_COUNT   = 1'b1
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_DIV1_LOAD,
    ST_DIV1,
    ST_RD_LO,
    ST_RD_HI,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_DIV2,
    ST_DEG_RD,
    ST_DEG_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [IDX_W-1:0]   entry_index;
    logic [VAL_W-1:0]   entry_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   dest_index;
    logic [VAL_W-1:0]   resampled_value;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/gamma_ramp_linear_resampler_top.sv -----
`default_nettype none

// Gamma ramp resampler: stores a 16-bit source ramp in a 4096-entry memory and
// answers queries for an entry of that ramp linearly resampled to dest_count
// entries, rounded to nearest. A write request is stored without leaving the
// idle state. A query holds off further requests until its result is loaded,
// and runs the 12 + 16 quotient steps of one shared restoring divider plus the
// shared multiplier and the two memory reads; a query with source_count or
// dest_count at most 1 returns entry 0 and skips the divider and multiplier. The result sits in
// an output register, so a write request is still taken while a result waits.
// Reading a source entry that was never written gives an undefined value.
module gamma_ramp_linear_resampler_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output      logic                       req_ready,
  input  wire grlr_pkg::req_t             req,
  output      logic                       rsp_valid,
  input  wire logic                       rsp_ready,
  output      grlr_pkg::rsp_t             rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);

  localparam int IDX_W  = grlr_pkg::IDX_W;
  localparam int VAL_W  = grlr_pkg::VAL_W;
  localparam int CNT_W  = grlr_pkg::CNT_W;
  localparam int PROD_W = grlr_pkg::PROD_W;
  localparam int STEP_W = grlr_pkg::STEP_W;

  grlr_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  source_count;
  logic [CNT_W-1:0]  dest_count;

  logic [IDX_W-1:0]  q_idx;
  logic [CNT_W-1:0]  q_sc;
  logic [CNT_W-1:0]  q_den;
  logic [IDX_W-1:0]  lo;
  logic [CNT_W-1:0]  frac;
  logic [VAL_W-1:0]  r_lo;
  logic [VAL_W-1:0]  r_hi;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  part;
  logic [VAL_W-1:0]  dq;
  logic [STEP_W-1:0] cnt;

  logic [VAL_W-1:0]  ramp_mem [grlr_pkg::TABLE_DEPTH];
  logic [VAL_W-1:0]  ramp_rdata;
  logic [IDX_W-1:0]  ramp_raddr;

  logic              req_fire;
  logic              cfg_write;
  logic              query_degen;
  logic [CNT_W-1:0]  sc_sat;
  logic [IDX_W-1:0]  idx_clamp;
  logic [IDX_W-1:0]  hi;
  logic [VAL_W-1:0]  mul_a;
  logic [CNT_W-1:0]  mul_b;
  logic [CNT_W:0]    step_t;
  logic              step_q;
  logic [CNT_W-1:0]  step_part;
  logic [PROD_W-1:0] acc_sum;
  logic              out_free;

  assign req_ready = (state == grlr_pkg::ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= CNT_W'(256);
      dest_count   <= CNT_W'(256);
    end else if (cfg_write) begin
      unique case (grlr_pkg::reg_idx_t'(paddr[2]))
        grlr_pkg::REG_SOURCE_COUNT: source_count <= pwdata[CNT_W-1:0];
        grlr_pkg::REG_DEST_COUNT:   dest_count   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (grlr_pkg::reg_idx_t'(paddr[2]))
      grlr_pkg::REG_SOURCE_COUNT: prdata = {{(32-CNT_W){1'b0}}, source_count};
      grlr_pkg::REG_DEST_COUNT:   prdata = {{(32-CNT_W){1'b0}}, dest_count};
      default:                    prdata = '0;
    endcase
  end

  // Query setup: saturate the source count, clamp the index, flag degenerate counts
  always_comb begin
    sc_sat = (source_count > CNT_W'(grlr_pkg::TABLE_DEPTH)) ?
             CNT_W'(grlr_pkg::TABLE_DEPTH) : source_count;
    if (dest_count == '0) begin
      idx_clamp = '0;
    end else if ({1'b0, req.entry_index} >= dest_count) begin
      idx_clamp = IDX_W'(dest_count - CNT_W'(1));
    end else begin
      idx_clamp = req.entry_index;
    end
    query_degen = (sc_sat <= CNT_W'(1)) || (dest_count <= CNT_W'(1));
  end

  // Ramp memory: write on write requests, registered read
  always_ff @(posedge clk) begin
    if (req_fire && req.func == grlr_pkg::FUNC_WRITE &&
        {1'b0, req.entry_index} < CNT_W'(grlr_pkg::TABLE_DEPTH)) begin
      ramp_mem[req.entry_index] <= req.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    ramp_rdata <= ramp_mem[ramp_raddr];
  end

  // Upper neighbor, held at the last source entry
  assign hi = (({1'b0, lo} + CNT_W'(1)) < q_sc) ? lo + IDX_W'(1) : lo;

  always_comb begin
    case (state)
      grlr_pkg::ST_RD_LO:  ramp_raddr = dq[IDX_W-1:0];
      grlr_pkg::ST_RD_HI:  ramp_raddr = hi;
      grlr_pkg::ST_DEG_RD: ramp_raddr = '0;
      default:             ramp_raddr = lo;
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    case (state)
      grlr_pkg::ST_MUL_NUM: begin
        mul_a = {{(VAL_W-IDX_W){1'b0}}, q_idx};
        mul_b = q_sc - CNT_W'(1);
      end
      grlr_pkg::ST_MUL_LO: begin
        mul_a = r_lo;
        mul_b = q_den - frac;
      end
      grlr_pkg::ST_MUL_HI: begin
        mul_a = r_hi;
        mul_b = frac;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Shared restoring divider step: shift in one dividend bit, trial subtract
  always_comb begin
    step_t    = {part, dq[VAL_W-1]};
    step_q    = (step_t >= {1'b0, q_den});
    step_part = step_q ? CNT_W'(step_t - {1'b0, q_den}) : step_t[CNT_W-1:0];
    acc_sum   = acc + prod;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grlr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      grlr_pkg::ST_IDLE: begin
        if (req_fire && req.func == grlr_pkg::FUNC_QUERY) begin
          state_next = query_degen ? grlr_pkg::ST_DEG_RD : grlr_pkg::ST_MUL_NUM;
        end
      end
      grlr_pkg::ST_MUL_NUM:   state_next = grlr_pkg::ST_DIV1_LOAD;
      grlr_pkg::ST_DIV1_LOAD: state_next = grlr_pkg::ST_DIV1;
      grlr_pkg::ST_DIV1: begin
        if (cnt == STEP_W'(grlr_pkg::DIV1_STEPS - 1)) begin
          state_next = grlr_pkg::ST_RD_LO;
        end
      end
      grlr_pkg::ST_RD_LO:     state_next = grlr_pkg::ST_RD_HI;
      grlr_pkg::ST_RD_HI:     state_next = grlr_pkg::ST_MUL_LO;
      grlr_pkg::ST_MUL_LO:    state_next = grlr_pkg::ST_MUL_HI;
      grlr_pkg::ST_MUL_HI:    state_next = grlr_pkg::ST_ACC;
      grlr_pkg::ST_ACC:       state_next = grlr_pkg::ST_DIV2;
      grlr_pkg::ST_DIV2: begin
        if (cnt == STEP_W'(grlr_pkg::DIV2_STEPS - 1)) begin
          state_next = grlr_pkg::ST_DONE;
        end
      end
      grlr_pkg::ST_DEG_RD:    state_next = grlr_pkg::ST_DEG_WAIT;
      grlr_pkg::ST_DEG_WAIT:  state_next = grlr_pkg::ST_DONE;
      grlr_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = grlr_pkg::ST_IDLE;
        end
      end
      default:                state_next = grlr_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      grlr_pkg::ST_IDLE: begin
        if (req_fire && req.func == grlr_pkg::FUNC_QUERY) begin
          q_idx <= idx_clamp;
          q_sc  <= sc_sat;
          q_den <= dest_count - CNT_W'(1);
        end
      end
      grlr_pkg::ST_DIV1_LOAD: begin
        part <= {{(CNT_W-IDX_W){1'b0}}, prod[2*IDX_W-1:IDX_W]};
        dq   <= {prod[IDX_W-1:0], {(VAL_W-IDX_W){1'b0}}};
        cnt  <= '0;
      end
      grlr_pkg::ST_DIV1, grlr_pkg::ST_DIV2: begin
        part <= step_part;
        dq   <= {dq[VAL_W-2:0], step_q};
        cnt  <= cnt + STEP_W'(1);
      end
      grlr_pkg::ST_RD_LO: begin
        lo   <= dq[IDX_W-1:0];
        frac <= part;
      end
      grlr_pkg::ST_RD_HI:  r_lo <= ramp_rdata;
      grlr_pkg::ST_MUL_LO: r_hi <= ramp_rdata;
      grlr_pkg::ST_MUL_HI: acc  <= prod + PROD_W'(q_den >> 1);
      grlr_pkg::ST_ACC: begin
        part <= acc_sum[PROD_W-1:VAL_W];
        dq   <= acc_sum[VAL_W-1:0];
        cnt  <= '0;
      end
      grlr_pkg::ST_DEG_WAIT: dq <= ramp_rdata;
      default: ;
    endcase
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == grlr_pkg::ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == grlr_pkg::ST_DONE && out_free) begin
      rsp.dest_index      <= q_idx;
      rsp.resampled_value <= dq;
    end
  end

`ifndef SYNTHESIS
  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == grlr_pkg::FUNC_QUERY) |=> state != grlr_pkg::ST_IDLE)
    else $error("query request did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == grlr_pkg::FUNC_WRITE) |=> state == grlr_pkg::ST_IDLE)
    else $error("write request left the idle state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == grlr_pkg::ST_DONE)
    else $error("result raised outside the done state");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == grlr_pkg::ST_DONE && rsp_valid && !rsp_ready) |=>
      state == grlr_pkg::ST_DONE)
    else $error("pending result overwritten");

  a_div1_count: assert property (@(posedge clk) disable iff (rst)
    state == grlr_pkg::ST_DIV1 |-> cnt < STEP_W'(grlr_pkg::DIV1_STEPS))
    else $error("index divider ran past its quotient width");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
  import grlr_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the block state and its count registers
  logic [VAL_W-1:0] ramp_mirror [TABLE_DEPTH];
  bit               ramp_loaded [TABLE_DEPTH];
  logic [CNT_W-1:0] src_count = CNT_W'(256);
  logic [CNT_W-1:0] dst_count = CNT_W'(256);

  rsp_t pending_samples [$];
  int   fail_count = 0;

  // Receiver idling controls
  bit quiet = 1'b0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  gamma_ramp_linear_resampler_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h actual %h", what, want, got);
  endtask

  // Compute the resampled entry for a query; also return the source taps read
  function automatic rsp_t resample_entry(input req_t item, output int lo_tap,
                                          output int hi_tap);
    logic [CNT_W-1:0] sc;
    logic [CNT_W-1:0] dc;
    logic [IDX_W-1:0] idx;
    longint unsigned  num, den, lo, rem, hi, acc;
    rsp_t             res;
    sc = src_count;
    if (sc > TABLE_DEPTH) sc = CNT_W'(TABLE_DEPTH);
    dc = dst_count;
    idx = item.entry_index;
    // Clamp the destination index into range
    if (dc == 0) idx = '0;
    else if ({1'b0, idx} >= dc) idx = IDX_W'(dc - 1'b1);
    res.dest_index = idx;
    if (sc <= 1 || dc <= 1) begin
      lo_tap = 0;
      hi_tap = 0;
      res.resampled_value = ramp_mirror[0];
    end else begin
      num = 64'(idx) * 64'(sc - 1'b1);
      den = 64'(dc) - 1;
      lo = num / den;
      rem = num % den;
      hi = (lo + 1 < 64'(sc)) ? lo + 1 : lo;
      acc = 64'(ramp_mirror[lo]) * (den - rem) + 64'(ramp_mirror[hi]) * rem + den / 2;
      res.resampled_value = VAL_W'(acc / den);
      lo_tap = int'(lo);
      hi_tap = int'(hi);
    end
    return res;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_req(input req_t item);
    int gap;
    int lo_tap, hi_tap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    if (item.func == FUNC_WRITE) begin
      ramp_mirror[item.entry_index] = item.entry_value;
      ramp_loaded[item.entry_index] = 1'b1;
    end else begin
      pending_samples.push_back(resample_entry(item, lo_tap, hi_tap));
    end
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    req_t item;
    item.func = FUNC_WRITE;
    item.entry_index = idx;
    item.entry_value = val;
    send_req(item);
  endtask

  task automatic send_query(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    req_t item;
    int   lo_tap, hi_tap;
    item.func = FUNC_QUERY;
    item.entry_index = idx;
    item.entry_value = val;
    void'(resample_entry(item, lo_tap, hi_tap));
    // Load any tap the query reads that holds no data yet
    if (!ramp_loaded[lo_tap]) send_write(IDX_W'(lo_tap), VAL_W'($urandom));
    if (!ramp_loaded[hi_tap]) send_write(IDX_W'(hi_tap), VAL_W'($urandom));
    send_req(item);
  endtask

  // Stop offering, wait for every result, then let the block go quiet
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t r, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (r == REG_SOURCE_COUNT) src_count = data[CNT_W-1:0];
    else dst_count = data[CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic apb_read_check(input reg_idx_t r, input logic [31:0] want);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch(r == REG_SOURCE_COUNT ? "source_count read" :
                                      "dest_count read", want, got);
    @(posedge clk);
  endtask

  task automatic set_counts(input logic [CNT_W-1:0] sc, input logic [CNT_W-1:0] dc);
    apb_write(REG_SOURCE_COUNT, 32'(sc));
    apb_write(REG_DEST_COUNT, 32'(dc));
    apb_read_check(REG_SOURCE_COUNT, 32'(sc));
    apb_read_check(REG_DEST_COUNT, 32'(dc));
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return CNT_W'($urandom_range(0, 1));
      1: return CNT_W'(TABLE_DEPTH);
      2: return CNT_W'($urandom_range(TABLE_DEPTH + 1, 8191));
      3: return CNT_W'(2);
      4: return CNT_W'($urandom_range(2, 16));
      default: return CNT_W'($urandom_range(1, TABLE_DEPTH));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_query_index();
    if (dst_count >= 1 && dst_count <= TABLE_DEPTH && $urandom_range(0, 1))
      return IDX_W'($urandom_range(0, dst_count - 1));
    return IDX_W'($urandom);
  endfunction

  // Reset values, then both register extremes with readback
  task automatic test_register_access();
    apb_read_check(REG_SOURCE_COUNT, 32'd256);
    apb_read_check(REG_DEST_COUNT, 32'd256);
    set_counts(13'h1FFF, 13'h1FFF);
    set_counts('0, '0);
  endtask

  task automatic test_directed();
    // Zero counts: degenerate path, index clamped to zero
    send_write(12'd0, 16'hFFFF);
    send_query(12'hFFF, 16'h0000);
    drain_results();
    // Unit scale: last entry, oversized index, ignored value field
    set_counts(13'd256, 13'd256);
    send_write(12'd255, 16'h0000);
    send_query(12'd255, 16'h0000);
    send_query(12'hFFF, 16'hFFFF);
    send_query(12'd0, 16'h0000);
    drain_results();
    // Single source entry, then single destination entry
    set_counts(13'd1, 13'd4096);
    send_query(12'hFFF, 16'h1234);
    drain_results();
    set_counts(13'd4096, 13'd1);
    send_query(12'd0, 16'h0000);
    drain_results();
    // Source count above the table depth saturates
    set_counts(13'h1FFF, 13'd4096);
    send_write(12'hFFF, 16'h8000);
    send_query(12'hFFF, 16'h0000);
    send_query(12'hFFE, 16'h0000);
    drain_results();
    // Two-entry ramp stretched wide: exercise rounding near the midpoint
    set_counts(13'd2, 13'd4096);
    send_write(12'd0, 16'h0000);
    send_write(12'd1, 16'hFFFF);
    send_query(12'd2047, 16'h0000);
    send_query(12'd2048, 16'h0000);
    send_query(12'hFFF, 16'h0000);
    drain_results();
    // Destination count beyond the index range
    set_counts(13'd4096, 13'h1FFF);
    send_query(12'hFFF, 16'h0000);
    send_query(12'd1, 16'h0000);
    drain_results();
  endtask

  task automatic test_random_traffic(input int phases, input int items_per_phase);
    for (int p = 0; p < phases; p++) begin
      drain_results();
      set_counts(pick_count(), pick_count());
      for (int n = 0; n < items_per_phase; n++) begin
        if ($urandom_range(0, 9) < 3) send_write(IDX_W'($urandom), VAL_W'($urandom));
        else send_query(pick_query_index(), VAL_W'($urandom));
      end
    end
    drain_results();
  endtask

  // Hold off the receiver while queries keep coming, so the input stalls
  task automatic test_backpressure();
    drain_results();
    set_counts(CNT_W'($urandom_range(2, TABLE_DEPTH)), CNT_W'($urandom_range(2, TABLE_DEPTH)));
    hold_ticket++;
    for (int n = 0; n < 16; n++) send_query(pick_query_index(), VAL_W'($urandom));
    drain_results();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    test_random_traffic(2, 38);
  endtask

  // Receiver: long hold on request, otherwise random short stalls
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest pending sample
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result", '0, 32'(rsp));
      end else begin
        want = pending_samples.pop_front();
        if (rsp.dest_index !== want.dest_index)
          report_mismatch("dest_index", 32'(want.dest_index), 32'(rsp.dest_index));
        if (rsp.resampled_value !== want.resampled_value)
          report_mismatch("resampled_value", 32'(want.resampled_value),
                          32'(rsp.resampled_value));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed();
    test_random_traffic(10, 38);
    test_backpressure();
    test_quiet_tail();
    drain_results();
    if (fail_count == 0 && pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
